>>> sv/wepl_pkg.sv
// shared types and constants of the wheel effort power limiter
package wepl_pkg;

  // default sizes handed to the top level parameters
  localparam int EFFORT_BITS_DEF = 16;
  localparam int MAX_JOINTS_DEF  = 8;

  // fixed field widths
  localparam int VEL_BITS  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  // the power budget carries four fraction bits, the others eight
  localparam int Q_ADJ     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_COEFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VELOCITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_BUDGET = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] POWER_COEFF_RST  = 16'd256;
  localparam logic [CFG_W-1:0] MIN_VELOCITY_RST = 16'd256;
  localparam logic [CFG_W-1:0] POWER_BUDGET_RST = 16'd1280;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic load;
    logic mul;
    logic cmp;
    logic div_step;
    logic out_load;
    logic out_last;
    logic clear_set;
  } wepl_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic bypass;
    logic out_free;
  } wepl_status_t;

endpackage

>>> sv/wepl_ram.sv
// generic single-write, single-read ram with registered read data
module wepl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/wepl_ctrl.sv
// sequencer: collects a set of joints, then steps each stored joint through the datapath
module wepl_ctrl
  import wepl_pkg::*;
#(
  parameter int EFFORT_BITS = EFFORT_BITS_DEF,
  parameter int MAX_JOINTS  = MAX_JOINTS_DEF,
  localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_joint,
  output logic               in_ready,
  output logic [IDX_W-1:0]   addr,
  output wepl_cmd_t          cmd,
  input  wepl_status_t       st
);

  localparam int CNT_W  = $clog2(MAX_JOINTS + 1);
  localparam int STEP_W = $clog2(EFFORT_BITS);

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_LOAD    = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_CMP     = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  k, k_next;
  logic [STEP_W-1:0] step, step_next;
  logic              is_last;

  // final result of the set
  assign is_last = (CNT_W'(k) + CNT_W'(1)) == count;

  // next state and commands
  always_comb begin
    state_next = state;
    count_next = count;
    k_next     = k;
    step_next  = step;
    cmd        = '0;
    addr       = k;
    in_ready   = 1'b0;
    case (state)
      S_COLLECT: begin
        in_ready = 1'b1;
        addr     = count[IDX_W-1:0];
        if (in_valid) begin
          cmd.wr_en  = 1'b1;
          count_next = count + CNT_W'(1);
          // the set closes on the flag or when the store is full
          if (last_joint || (count + CNT_W'(1)) == CNT_W'(MAX_JOINTS)) begin
            k_next     = '0;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        step_next  = '0;
        state_next = st.bypass ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(EFFORT_BITS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = is_last;
          if (is_last) begin
            cmd.clear_set = 1'b1;
            count_next    = '0;
            state_next    = S_COLLECT;
          end else begin
            k_next     = k + IDX_W'(1);
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      count <= '0;
      k     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      k     <= k_next;
      step  <= step_next;
    end
  end

endmodule

>>> sv/wepl_dp.sv
// datapath: configuration, joint store, effort total, cap arithmetic, divider and output register
module wepl_dp
  import wepl_pkg::*;
#(
  parameter int EFFORT_BITS = EFFORT_BITS_DEF,
  parameter int MAX_JOINTS  = MAX_JOINTS_DEF,
  localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic signed [EFFORT_BITS-1:0] effort_cmd,
  input  logic signed [VEL_BITS-1:0]    joint_velocity,
  input  logic                          is_wheel,
  input  logic [IDX_W-1:0]              addr,
  input  wepl_cmd_t                     cmd,
  output wepl_status_t                  st,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [EFFORT_BITS-1:0] limited_effort,
  output logic                          last_result
);

  localparam int E       = EFFORT_BITS;
  localparam int ROW_W   = E + VEL_BITS + 1;
  localparam int TOTAL_W = E - 1 + $clog2(MAX_JOINTS + 1);
  localparam int DEN_W   = TOTAL_W + VEL_BITS;
  localparam int CL_W    = 2 * CFG_W;
  localparam int P_W     = CL_W + Q_ADJ;
  localparam int NUM_W   = CL_W + E;
  localparam int CMP_W   = (P_W > DEN_W) ? P_W : DEN_W;

  logic [CFG_W-1:0]   power_coeff, min_velocity, power_budget;
  logic [TOTAL_W-1:0] total;
  logic [CL_W-1:0]    coeff_limit;
  logic [ROW_W-1:0]   rd_row;
  logic [E-1:0]       eff, mag;
  logic               wheel;
  logic [VEL_BITS-1:0] vdiv;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den, rem;
  logic [E-1:0]       quo;
  logic               bypass;
  logic [E-1:0]       in_mag, rd_eff, rd_mag;
  logic [VEL_BITS-1:0] rd_vel, rd_vmag, vfloor;
  logic               rd_wheel;
  logic [P_W-1:0]     pwr;
  logic               bypass_now;
  logic [DEN_W:0]     trial;
  logic               fits;
  logic [E-1:0]       lim_signed, result;

  // joint store: wheel flag, velocity and effort in one row
  wepl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_JOINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (addr),
    .wr_data ({is_wheel, joint_velocity, effort_cmd}),
    .rd_en   (cmd.rd_en),
    .rd_addr (addr),
    .rd_data (rd_row)
  );

  // configuration registers and effort total
  assign in_mag = effort_cmd[E-1] ? (~effort_cmd + E'(1)) : effort_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_coeff  <= POWER_COEFF_RST;
      min_velocity <= MIN_VELOCITY_RST;
      power_budget <= POWER_BUDGET_RST;
      total        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_POWER_COEFF:  power_coeff  <= cfg_data;
          CFG_MIN_VELOCITY: min_velocity <= cfg_data;
          CFG_POWER_BUDGET: power_budget <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear_set) begin
        total <= '0;
      end else if (cmd.wr_en && is_wheel) begin
        total <= total + TOTAL_W'(in_mag);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.out_free = !out_valid || out_ready;

  // unpack a stored row; the speed floor never lets the divisor reach zero
  assign rd_eff   = rd_row[E-1:0];
  assign rd_vel   = rd_row[E+VEL_BITS-1:E];
  assign rd_wheel = rd_row[ROW_W-1];
  assign rd_mag   = rd_eff[E-1] ? (~rd_eff + E'(1)) : rd_eff;
  assign rd_vmag  = rd_vel[VEL_BITS-1] ? (~rd_vel + VEL_BITS'(1)) : rd_vel;
  assign vfloor   = (min_velocity == '0) ? VEL_BITS'(1) : min_velocity;

  // scaled budget 16*coeff*budget against total*speed; the effort magnitude cancels
  assign pwr        = {coeff_limit, {Q_ADJ{1'b0}}};
  assign bypass_now = !wheel || (total == '0) || (CMP_W'(pwr) >= CMP_W'(den));
  assign st.bypass  = bypass_now;

  // one restoring divider step
  assign trial = {rem, quo[E-1]};
  assign fits  = trial >= {1'b0, den};

  // signed result
  assign lim_signed = eff[E-1] ? (~quo + E'(1)) : quo;
  assign result     = bypass ? eff : lim_signed;

  // arithmetic pipeline and divider
  always_ff @(posedge clk) begin
    coeff_limit <= power_coeff * power_budget;
    if (cmd.load) begin
      eff   <= rd_eff;
      mag   <= rd_mag;
      wheel <= rd_wheel;
      vdiv  <= (rd_vmag > vfloor) ? rd_vmag : vfloor;
    end
    if (cmd.mul) begin
      num <= coeff_limit * mag;
      den <= total * vdiv;
    end
    if (cmd.cmp) begin
      bypass <= bypass_now;
      // numerator is num*16: its upper bits seed the remainder
      rem    <= DEN_W'(num >> (E - Q_ADJ));
      quo    <= {num[E-Q_ADJ-1:0], {Q_ADJ{1'b0}}};
    end else if (cmd.div_step) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[E-2:0], fits};
    end
    if (cmd.out_load) begin
      limited_effort <= result;
      last_result    <= cmd.out_last;
    end
  end

endmodule

>>> sv/wheel_effort_power_limiter_core.sv
// top level of the wheel effort power limiter
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, effort_cmd, joint_velocity, | in
//          | is_wheel, last_joint                            |
//  out     | out_valid, out_ready, limited_effort,           | out
//          | last_result                                     |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | in
//
// Joints are taken one a cycle while a set is collected. Once the set closes,
// each stored joint passes through the sequencer (store read, load, multiply,
// compare, hand-off), plus the one-bit-a-cycle restoring divider for a wheel
// whose effort is actually capped. Reset is synchronous and restores the
// sequencer, configuration, total and output-valid registers to their reset
// values. A stalled result holds in the output register and the sequencer
// waits; no joint is taken while a set is being emitted.
module wheel_effort_power_limiter_core
  import wepl_pkg::*;
#(
  parameter int EFFORT_BITS = EFFORT_BITS_DEF,
  parameter int MAX_JOINTS  = MAX_JOINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [EFFORT_BITS-1:0] effort_cmd,
  input  logic signed [VEL_BITS-1:0]    joint_velocity,
  input  logic                          is_wheel,
  input  logic                          last_joint,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [EFFORT_BITS-1:0] limited_effort,
  output logic                          last_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  wepl_cmd_t        cmd;
  wepl_status_t     st;
  logic [IDX_W-1:0] ram_addr;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  wepl_ctrl #(
    .EFFORT_BITS(EFFORT_BITS),
    .MAX_JOINTS (MAX_JOINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_joint (last_joint),
    .in_ready   (in_ready),
    .addr       (ram_addr),
    .cmd        (cmd),
    .st         (st)
  );

  wepl_dp #(
    .EFFORT_BITS(EFFORT_BITS),
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .effort_cmd     (effort_cmd),
    .joint_velocity (joint_velocity),
    .is_wheel       (is_wheel),
    .addr           (ram_addr),
    .cmd            (cmd),
    .st             (st),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .limited_effort (limited_effort),
    .last_result    (last_result)
  );

  // store is never written and read in the same cycle
  a_no_wr_rd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.rd_en))
    else $error("store written and read together");

  // a result is only loaded when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("pending result overwritten");

  // reads stay inside the store
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (int'(ram_addr) < MAX_JOINTS))
    else $error("store read out of range");

  // no joint is taken while results are being produced
  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.div_step || cmd.out_load) |-> !in_ready)
    else $error("joint taken during emission");

endmodule
